### rtl/core/assert_macros.svh
// Assertion helpers; the including scope provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ICR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// When ante holds, cons holds in the next cycle.
`define ICR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/icr_pkg.sv
`timescale 1ns / 1ps

package icr_pkg;

  localparam int ADDR_W    = 26;
  localparam int SIZE_W    = 4;
  localparam int DATA_W    = 32;
  localparam int SRC_NUM_W = 6;
  localparam int CTX_NUM_W = 4;
  localparam int PRIO_W    = 3;

  localparam int SOURCES_DEF  = 63;
  localparam int CONTEXTS_DEF = 2;

  localparam int PRIORITY_BASE = 0;
  localparam int PENDING_BASE  = 4096;
  localparam int ENABLE_BASE   = 8192;
  localparam int REGION_SIZE   = 67108864;
  localparam int ENABLE_STRIDE = 'h80;
  localparam int ENABLE_SLOTS  = 16;
  localparam int CTX_SPAN      = 'h1000;

  localparam logic [SIZE_W-1:0] ACCESS_BYTES = 4'd4;
  localparam logic [3:0]        THR_NIB      = 4'h0;
  localparam logic [3:0]        CLAIM_NIB    = 4'h4;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_LINE,
    OP_CHECK
  } op_t;

  typedef enum logic [1:0] {
    FLT_NONE,
    FLT_LOAD,
    FLT_STORE
  } fault_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic line_wr;
    logic bus_wr;
    logic rd_issue;
    logic scan_start;
    logic scan_step;
    logic claim_set;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic chk_ok;
    logic clr_last;
    logic hit;
    logic last;
  } sts_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

### rtl/core/icr_ctrl.sv
`timescale 1ns / 1ps

module icr_ctrl
  import icr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.op)
          OP_LINE: begin
            cmd.line_wr = 1'b1;
            state_next  = ST_DONE;
          end
          OP_WRITE: begin
            cmd.bus_wr = 1'b1;
            state_next = ST_DONE;
          end
          OP_READ: begin
            cmd.rd_issue = 1'b1;
            state_next   = ST_RDWAIT;
          end
          OP_CHECK: begin
            if (sts.chk_ok) begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end else begin
              state_next = ST_DONE;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.claim_set = 1'b1;
          state_next    = ST_DONE;
        end else if (sts.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall       = (state != ST_IDLE);
  assign out_valid_next = cmd.out_ld | (out_valid & out_stall);

endmodule

### rtl/core/icr_dp.sv
`timescale 1ns / 1ps

module icr_dp
  import icr_pkg::*;
#(
  parameter int SOURCES  = SOURCES_DEF,
  parameter int CONTEXTS = CONTEXTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [1:0]           opcode,
  input  logic [ADDR_W-1:0]    bus_address,
  input  logic [SIZE_W-1:0]    access_size,
  input  logic [DATA_W-1:0]    write_value,
  input  logic                 line_level,
  input  logic [SRC_NUM_W-1:0] source_number,
  input  logic [CTX_NUM_W-1:0] target_context,
  output logic [DATA_W-1:0]    read_value,
  output logic [1:0]           fault_code,
  output logic                 irq_found
);

  localparam int WORDS     = (SOURCES + 32) / 32;
  localparam int SRC_W     = $clog2(SOURCES + 1);
  localparam int WIDX_W    = idx_w(WORDS);
  localparam int PEND_N    = WORDS * 32;
  localparam int PIDX_W    = $clog2(PEND_N);
  localparam int EN_N      = CONTEXTS * WORDS;
  localparam int EN_W      = idx_w(EN_N);
  localparam int CTX_W     = idx_w(CONTEXTS);
  localparam int SRC_MAX   = 2 ** SRC_NUM_W - 1;
  localparam int SCAN_LAST = (SOURCES < SRC_MAX) ? SOURCES : SRC_MAX;
  localparam int CLR_N     = ((SOURCES + 1) > EN_N) ? (SOURCES + 1) : EN_N;
  localparam int CLR_W     = idx_w(CLR_N);
  localparam int ADDR_OK   = REGION_SIZE - 4;
  localparam int PRIO_END  = PRIORITY_BASE + 4 * (SOURCES + 1);
  localparam int PEND_END  = PENDING_BASE + 4 * WORDS;
  localparam int EN_END    = ENABLE_BASE + ENABLE_STRIDE * ENABLE_SLOTS;
  localparam int EW_HI     = $clog2(ENABLE_STRIDE) - 1;
  localparam int EC_LO     = EW_HI + 1;
  localparam int EC_HI     = EC_LO + $clog2(ENABLE_SLOTS) - 1;
  localparam int CTX_LO    = $clog2(CTX_SPAN);

  // latched item
  op_t                  op_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [SIZE_W-1:0]    size_q;
  logic [DATA_W-1:0]    data_q;
  logic                 level_q;
  logic [SRC_NUM_W-1:0] src_q;
  logic [CTX_NUM_W-1:0] tctx_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(opcode);
      addr_q  <= bus_address;
      size_q  <= access_size;
      data_q  <= write_value;
      level_q <= line_level;
      src_q   <= source_number;
      tctx_q  <= target_context;
    end
  end

  // address decode
  logic                  fault;
  logic                  sel_prio, sel_pend, sel_en, sel_thr, sel_claim;
  logic                  in_pend, in_enr, en_hit, en_ctx_ok, rctx_ok, rest;
  logic [SRC_W-1:0]      p_idx;
  logic [WIDX_W-1:0]     pw;
  logic [EW_HI-2:0]      ew;
  logic [EC_HI-EC_LO:0]  ectx;
  logic [CTX_NUM_W-1:0]  rctx;
  logic [EN_W-1:0]       en_idx_bus;
  logic [CTX_W-1:0]      cidx;

  always_comb begin
    fault      = (size_q != ACCESS_BYTES) || (addr_q > ADDR_W'(ADDR_OK));
    // priority block starts at offset zero
    sel_prio   = addr_q < ADDR_W'(PRIO_END);
    p_idx      = addr_q[SRC_W+1:2];
    in_pend    = (addr_q >= ADDR_W'(PENDING_BASE)) && (addr_q < ADDR_W'(PEND_END));
    pw         = addr_q[WIDX_W+1:2];
    in_enr     = (addr_q >= ADDR_W'(ENABLE_BASE)) && (addr_q < ADDR_W'(EN_END));
    ew         = addr_q[EW_HI:2];
    ectx       = addr_q[EC_HI:EC_LO];
    en_hit     = in_enr && (32'(ew) < WORDS);
    en_ctx_ok  = 32'(ectx) < CONTEXTS;
    en_idx_bus = EN_W'(32'(ectx) * WORDS + 32'(ew));
    rctx       = addr_q[CTX_LO+CTX_NUM_W-1:CTX_LO];
    rctx_ok    = 32'(rctx) < CONTEXTS;
    sel_pend   = !sel_prio && in_pend;
    sel_en     = !sel_prio && !in_pend && en_hit;
    rest       = !sel_prio && !in_pend && !en_hit;
    sel_thr    = rest && (addr_q[3:0] == THR_NIB);
    sel_claim  = rest && (addr_q[3:0] == CLAIM_NIB);
    cidx       = (op_q == OP_CHECK) ? CTX_W'(tctx_q) : CTX_W'(rctx);
  end

  // clearing pass after reset
  logic [CLR_W-1:0] cl_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_cnt <= '0;
    end else if (cmd.clr_step) begin
      cl_cnt <= cl_cnt + CLR_W'(1);
    end
  end

  // scan pipeline: read issue, then evaluate in the next cycle
  logic [SRC_W-1:0] s_cnt;
  logic [SRC_W-1:0] s_d;
  logic             sd_vld;
  logic             iss_done;
  logic             issue;

  assign issue = cmd.scan_step && !iss_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_cnt    <= '0;
      s_d      <= '0;
      sd_vld   <= 1'b0;
      iss_done <= 1'b0;
    end else if (cmd.scan_start) begin
      s_cnt    <= SRC_W'(1);
      sd_vld   <= 1'b0;
      iss_done <= 1'b0;
    end else if (cmd.scan_step) begin
      sd_vld <= issue;
      if (issue) begin
        s_d <= s_cnt;
        if (s_cnt == SRC_W'(SCAN_LAST)) begin
          iss_done <= 1'b1;
        end else begin
          s_cnt <= s_cnt + SRC_W'(1);
        end
      end
    end
  end

  // priority memory
  logic [PRIO_W-1:0] prio_mem [0:SOURCES];
  logic [PRIO_W-1:0] prio_rd;
  logic              prio_we, prio_re;
  logic [SRC_W-1:0]  prio_wa, prio_ra;
  logic [PRIO_W-1:0] prio_wd;

  // enable memory
  logic [DATA_W-1:0] en_mem [0:EN_N-1];
  logic [DATA_W-1:0] en_rd;
  logic              en_we, en_re;
  logic [EN_W-1:0]   en_wa, en_ra;
  logic [DATA_W-1:0] en_wd;

  logic bus_ok_wr;
  assign bus_ok_wr = cmd.bus_wr && !fault;

  always_comb begin
    prio_we = 1'b0;
    prio_wa = p_idx;
    prio_wd = data_q[PRIO_W-1:0];
    en_we   = 1'b0;
    en_wa   = en_idx_bus;
    en_wd   = (ew == '0) ? {data_q[DATA_W-1:1], 1'b0} : data_q;
    if (cmd.clr_step) begin
      prio_we = 32'(cl_cnt) <= SOURCES;
      prio_wa = cl_cnt[SRC_W-1:0];
      prio_wd = '0;
      en_we   = 32'(cl_cnt) < EN_N;
      en_wa   = cl_cnt[EN_W-1:0];
      en_wd   = '0;
    end else if (bus_ok_wr) begin
      // source zero has a fixed priority of zero
      prio_we = sel_prio && (p_idx != '0);
      en_we   = sel_en && en_ctx_ok;
    end
    prio_re = issue || (cmd.rd_issue && sel_prio);
    prio_ra = issue ? s_cnt : p_idx;
    en_re   = issue || (cmd.rd_issue && sel_en && en_ctx_ok);
    en_ra   = issue ? EN_W'(32'(tctx_q) * WORDS + (32'(s_cnt) >> 5)) : en_idx_bus;
  end

  always_ff @(posedge clk) begin
    if (prio_we) prio_mem[prio_wa] <= prio_wd;
    if (prio_re) prio_rd <= prio_mem[prio_ra];
  end

  always_ff @(posedge clk) begin
    if (en_we) en_mem[en_wa] <= en_wd;
    if (en_re) en_rd <= en_mem[en_ra];
  end

  // pending bits, thresholds, claims
  logic [PEND_N-1:0]    pend;
  logic [PRIO_W-1:0]    thr   [CONTEXTS];
  logic [SRC_NUM_W-1:0] claim [CONTEXTS];
  logic                 found;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (cmd.line_wr && (src_q != '0) && (32'(src_q) <= SOURCES)) begin
      pend[PIDX_W'(src_q)] <= level_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONTEXTS; i++) begin
        thr[i]   <= '0;
        claim[i] <= '0;
      end
    end else begin
      if (bus_ok_wr && sel_thr && rctx_ok) thr[cidx] <= data_q[PRIO_W-1:0];
      if (bus_ok_wr && sel_claim && rctx_ok) begin
        claim[cidx] <= '0;
      end else if (cmd.claim_set) begin
        claim[cidx] <= SRC_NUM_W'(s_d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.claim_set) begin
      found <= 1'b1;
    end
  end

  // status
  always_comb begin
    sts.op       = op_q;
    sts.chk_ok   = 32'(tctx_q) < CONTEXTS;
    sts.clr_last = cl_cnt == CLR_W'(CLR_N - 1);
    sts.hit      = sd_vld && pend[PIDX_W'(s_d)] && en_rd[5'(s_d)] && (prio_rd > thr[cidx]);
    sts.last     = sd_vld && (s_d == SRC_W'(SCAN_LAST));
  end

  // read data and result word
  logic [DATA_W-1:0] rd_val;
  fault_t            flt;

  always_comb begin
    rd_val = '0;
    if (sel_prio) begin
      rd_val = DATA_W'(prio_rd);
    end else if (sel_pend) begin
      rd_val = pend[32 * 32'(pw) +: DATA_W];
    end else if (sel_en && en_ctx_ok) begin
      rd_val = en_rd;
    end else if (sel_thr && rctx_ok) begin
      rd_val = DATA_W'(thr[cidx]);
    end else if (sel_claim && rctx_ok) begin
      rd_val = DATA_W'(claim[cidx]);
    end
    flt = FLT_NONE;
    if (fault && (op_q == OP_READ)) flt = FLT_LOAD;
    if (fault && (op_q == OP_WRITE)) flt = FLT_STORE;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      read_value <= ((op_q == OP_READ) && !fault) ? rd_val : '0;
      fault_code <= flt;
      irq_found  <= found;
    end
  end

endmodule

### rtl/core/interrupt_controller_regs_top.sv
// Channel | Handshake           | Word
// --------+---------------------+------------------------------------------------
// in      | in_valid / in_stall | opcode, bus_address, access_size, write_value,
//         |                     | line_level, source_number, target_context
// out     | out_valid/out_stall | read_value, fault_code, irq_found
//
// One item at a time. A bus read goes through a registered memory read; a check of
// an out-of-range context ends without a scan. Other checks stop at the first
// qualifying source or after source min(SOURCES, 63); the serial scan takes one
// source per cycle through the priority and enable memories.
// After reset, a clearing pass zeroes both memories with in_stall high.
// A waiting result sits in the output register; out_stall holds it there and
// the next item is taken meanwhile, holding at its last step until the register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module interrupt_controller_regs_top
  import icr_pkg::*;
#(
  parameter int SOURCES  = SOURCES_DEF,
  parameter int CONTEXTS = CONTEXTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [ADDR_W-1:0]    bus_address,
  input  logic [SIZE_W-1:0]    access_size,
  input  logic [DATA_W-1:0]    write_value,
  input  logic                 line_level,
  input  logic [SRC_NUM_W-1:0] source_number,
  input  logic [CTX_NUM_W-1:0] target_context,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    read_value,
  output logic [1:0]           fault_code,
  output logic                 irq_found
);

  cmd_t cmd;
  sts_t sts;

  icr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  icr_dp #(
    .SOURCES  (SOURCES),
    .CONTEXTS (CONTEXTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (opcode),
    .bus_address    (bus_address),
    .access_size    (access_size),
    .write_value    (write_value),
    .line_level     (line_level),
    .source_number  (source_number),
    .target_context (target_context),
    .read_value     (read_value),
    .fault_code     (fault_code),
    .irq_found      (irq_found)
  );

  `ICR_ASSERT(a_fault_clean, (out_valid && fault_code != FLT_NONE) |-> (read_value == '0 && !irq_found), "faulted word carries data or irq")
  `ICR_ASSERT(a_claim_on_hit, cmd.claim_set |-> sts.hit, "claim updated without a qualifying source")
  `ICR_ASSERT_NEXT(a_out_after_ld, cmd.out_ld, out_valid, "result loaded but not presented")
  `ICR_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second word taken while busy")

endmodule
